// File: hdl/ksv_pkg.sv
// Shared types, constants and helpers for the plucked-string voice.
// No dependencies; imported by every module of the voice except ksv_ram.
package ksv_pkg;

  localparam int LINE_DEPTH_DEF = 1024;

  localparam int SR_W   = 17;
  localparam int GAIN_W = 16;
  localparam int FREQ_W = 25;
  localparam int AMP_W  = 16;
  localparam int SMP_W  = 16;
  localparam int FRAC_W = 16;

  // rate << 24 over frequency
  localparam int DVD_W = SR_W + 24;
  localparam int DVS_W = FREQ_W;

  localparam logic [SR_W-1:0]   SR_RESET   = SR_W'(48000);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65274);
  localparam logic [31:0]       SEED_RESET = 32'd777;
  localparam logic [31:0]       LCG_MUL    = 32'd1664525;
  localparam logic [31:0]       LCG_ADD    = 32'd1013904223;
  localparam logic [AMP_W-1:0]  AMP_FULL   = AMP_W'(32768);
  localparam int                MIN_LEN    = 4;
  localparam int                HALF_Q16   = 32768;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = SR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_DECAY_GAIN  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LEN,
    S_LP,
    S_SCALE,
    S_STORE,
    S_RD1,
    S_INTERP,
    S_SUM,
    S_FBK,
    S_EMIT
  } voice_state_t;

  typedef enum logic [1:0] {
    MOP_LCG,
    MOP_SCALE,
    MOP_INTERP,
    MOP_DECAY
  } mul_op_t;

  typedef struct packed {
    logic [31:0]              seed;
    logic signed [SMP_W-1:0]  lp;
    logic [AMP_W-1:0]         amp;
    logic signed [SMP_W:0]    diff;
    logic [FRAC_W-1:0]        frac;
    logic signed [SMP_W:0]    fsum;
    logic [GAIN_W-1:0]        gain;
  } mac_opnd_t;

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [MUL_P_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > MUL_P_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -MUL_P_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/ksv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ksv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ksv_div.sv
// Restoring divider, one quotient bit per cycle, for the loop-length division.
// Depends on ksv_pkg.
module ksv_div import ksv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  // dividend bits shift out at the top while quotient bits shift in at the bottom
  logic [DVD_W-1:0] quo_r, quo_nxt;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] trial_sub;
  logic           ge;

  always_comb begin
    trial     = {rem_r, quo_r[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    // zero divisor: every step subtracts nothing, the quotient saturates to all ones
    ge        = (trial >= {1'b0, dvs_r});

    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/ksv_mac.sv
// Shared signed multiplier with operand select and registered product.
// Depends on ksv_pkg.
module ksv_mac import ksv_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  mul_op_t                   op,
  input  mac_opnd_t                 opnd,
  output logic signed [MUL_P_W-1:0] prod_r
);

  logic signed [MUL_A_W-1:0] a_sel;
  logic signed [MUL_B_W-1:0] b_sel;

  always_comb begin
    unique case (op)
      MOP_LCG: begin
        a_sel = {1'b0, opnd.seed};
        b_sel = MUL_B_W'(LCG_MUL);
      end
      MOP_SCALE: begin
        a_sel = {{(MUL_A_W-SMP_W){opnd.lp[SMP_W-1]}}, opnd.lp};
        b_sel = {{(MUL_B_W-AMP_W){1'b0}}, opnd.amp};
      end
      MOP_INTERP: begin
        a_sel = {{(MUL_A_W-SMP_W-1){opnd.diff[SMP_W]}}, opnd.diff};
        b_sel = {{(MUL_B_W-FRAC_W){1'b0}}, opnd.frac};
      end
      MOP_DECAY: begin
        a_sel = {{(MUL_A_W-SMP_W-1){opnd.fsum[SMP_W]}}, opnd.fsum};
        b_sel = {{(MUL_B_W-GAIN_W){1'b0}}, opnd.gain};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a_sel * b_sel;
    end
  end

endmodule

// File: hdl/plucked_string_synth_voice.sv
// Top level of the plucked-string voice: sequencer, state and configuration.
// Depends on ksv_pkg, ksv_ram, ksv_div and ksv_mac.
//
// One Karplus-Strong string. A tick on an active voice steps through RD1, INTERP,
// SUM, FBK and EMIT; its result is registered in EMIT, which waits while the result
// register is still held by out_stall. The delay line has one read port, so the two
// interpolation taps are read on consecutive cycles, and one shared multiplier
// handles interpolation and feedback in turn. A pluck transfer runs a bit-serial
// division for rate/frequency, then writes floor(L)+2 noise samples, L being the new
// loop length in samples, each through the shared multiplier (noise generator step,
// amplitude scaling, write). A pluck gives no result. in_stall is high for the whole
// time an item is in work.
// The delay line needs no clearing after reset: a tick only reads
// locations written by the latest pluck or by later ticks.
module plucked_string_synth_voice import ksv_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  logic [FREQ_W-1:0]       in_freq_hz,
  input  logic [AMP_W-1:0]        in_amplitude,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SMP_W-1:0] out_sample,
  output logic                    out_voice_active
);

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int LEN_W = AW + FRAC_W;
  localparam logic [LEN_W-1:0] LEN_LO = LEN_W'(MIN_LEN << FRAC_W);
  localparam logic [LEN_W-1:0] LEN_HI = LEN_W'((LINE_DEPTH - MIN_LEN) << FRAC_W);
  localparam logic [DVD_W-1:0] Q_LO   = DVD_W'((MIN_LEN << FRAC_W) + HALF_Q16);
  localparam logic [DVD_W-1:0] Q_HI   = DVD_W'(((LINE_DEPTH - MIN_LEN) << FRAC_W) + HALF_Q16);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    if (v == AW'(LINE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = v + AW'(1);
    end
    return r;
  endfunction

  voice_state_t state_r, state_nxt;

  logic [SR_W-1:0]         sample_rate_r;
  logic [GAIN_W-1:0]       decay_gain_r;

  logic [AW-1:0]           wp_r, wp_nxt;
  logic [LEN_W-1:0]        loop_len_r, loop_len_nxt;
  logic signed [SMP_W-1:0] prev_r, prev_nxt;
  logic                    active_r, active_nxt;
  logic [31:0]             seed_r, seed_nxt;
  logic signed [SMP_W-1:0] lp_r, lp_nxt;
  logic [AMP_W-1:0]        amp_r, amp_nxt;
  logic [AW-1:0]           fill_cnt_r, fill_cnt_nxt;
  logic [AW-1:0]           fill_addr_r, fill_addr_nxt;
  logic [AW-1:0]           i1_r, i1_nxt;
  logic [FRAC_W-1:0]       frac_r, frac_nxt;
  logic signed [SMP_W-1:0] a_r, a_nxt;
  logic signed [SMP_W-1:0] y_r, y_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] out_sample_r, out_sample_nxt;
  logic                    out_act_r, out_act_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [SMP_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [SMP_W-1:0]        ram_rdata;

  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [DVD_W-1:0]        div_quo;

  logic                      mac_en;
  mul_op_t                   mac_op;
  mac_opnd_t                 mac_opnd;
  logic signed [MUL_P_W-1:0] prod_r;

  logic                    in_xfer;
  logic                    out_free;

  // tick geometry
  logic [AW:0]             ip_sum;
  logic [AW-1:0]           i0_w;
  logic [AW-1:0]           i1_w;
  logic [FRAC_W-1:0]       frac_w;

  // pluck helpers
  logic [LEN_W-1:0]        len_clamped;
  logic [AW-1:0]           fill_n;
  logic [AW-1:0]           fill_start;
  logic signed [SMP_W-1:0] noise_x;
  logic signed [SMP_W:0]   lp_sum;
  logic signed [SMP_W-1:0] lp_new;
  logic [AMP_W-1:0]        amp_clamped;

  logic signed [MUL_P_W-1:0] a_ext;
  logic signed [SMP_W-1:0]   y_calc;
  logic signed [SMP_W-1:0]   fb_calc;
  logic signed [SMP_W-1:0]   store_calc;

  ksv_ram #(
    .WIDTH (SMP_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ksv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sample_rate_r, 24'd0}),
    .divisor  (in_freq_hz),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  ksv_mac u_mac (
    .clk    (clk),
    .en     (mac_en),
    .op     (mac_op),
    .opnd   (mac_opnd),
    .prod_r (prod_r)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    // read position = wp - L, integer part borrows when the fraction is nonzero
    ip_sum = {1'b0, wp_r} + (AW+1)'(LINE_DEPTH) - {1'b0, loop_len_r[LEN_W-1:FRAC_W]}
             - (AW+1)'(loop_len_r[FRAC_W-1:0] != '0);
    if (ip_sum >= (AW+1)'(LINE_DEPTH)) begin
      i0_w = AW'(ip_sum - (AW+1)'(LINE_DEPTH));
    end else begin
      i0_w = ip_sum[AW-1:0];
    end
    i1_w   = wrap_inc(i0_w);
    frac_w = FRAC_W'(16'd0 - loop_len_r[FRAC_W-1:0]);

    if (div_quo < Q_LO) begin
      len_clamped = LEN_LO;
    end else if (div_quo > Q_HI) begin
      len_clamped = LEN_HI;
    end else begin
      len_clamped = LEN_W'(div_quo - DVD_W'(HALF_Q16));
    end

    fill_n = loop_len_r[LEN_W-1:FRAC_W] + AW'(2);
    if (wp_r >= fill_n) begin
      fill_start = wp_r - fill_n;
    end else begin
      fill_start = AW'({1'b0, wp_r} + (AW+1)'(LINE_DEPTH) - {1'b0, fill_n});
    end

    noise_x = seed_r[31:16];
    lp_sum  = {lp_r[SMP_W-1], lp_r} + {noise_x[SMP_W-1], noise_x};
    lp_new  = lp_sum[SMP_W:1];

    amp_clamped = (in_amplitude > AMP_FULL) ? AMP_FULL : in_amplitude;

    a_ext      = {{(MUL_P_W-SMP_W){a_r[SMP_W-1]}}, a_r};
    y_calc     = sat16(a_ext + (prod_r >>> FRAC_W));
    fb_calc    = sat16(prod_r >>> (FRAC_W + 1));
    store_calc = sat16(prod_r >>> (SMP_W - 1));
  end

  always_comb begin
    mac_opnd.seed = seed_r;
    mac_opnd.lp   = lp_new;
    mac_opnd.amp  = amp_r;
    mac_opnd.diff = {ram_rdata[SMP_W-1], ram_rdata} - {a_r[SMP_W-1], a_r};
    mac_opnd.frac = frac_r;
    mac_opnd.fsum = {y_r[SMP_W-1], y_r} + {prev_r[SMP_W-1], prev_r};
    mac_opnd.gain = decay_gain_r;
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    loop_len_nxt  = loop_len_r;
    prev_nxt      = prev_r;
    active_nxt    = active_r;
    seed_nxt      = seed_r;
    lp_nxt        = lp_r;
    amp_nxt       = amp_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_addr_nxt = fill_addr_r;
    i1_nxt        = i1_r;
    frac_nxt      = frac_r;
    a_nxt         = a_r;
    y_nxt         = y_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_act_nxt    = out_act_r;

    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = fb_calc;
    ram_raddr = i0_w;
    div_start = 1'b0;
    mac_en    = 1'b0;
    mac_op    = MOP_LCG;

    unique case (state_r)
      S_IDLE: begin
        // first tap read is issued on the transfer cycle itself
        ram_raddr = i0_w;
        if (in_xfer) begin
          if (in_action) begin
            div_start = 1'b1;
            amp_nxt   = amp_clamped;
            state_nxt = S_DIV;
          end else if (active_r) begin
            i1_nxt    = i1_w;
            frac_nxt  = frac_w;
            state_nxt = S_RD1;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          loop_len_nxt = len_clamped;
          state_nxt    = S_LEN;
        end
      end
      S_LEN: begin
        fill_cnt_nxt  = fill_n;
        fill_addr_nxt = fill_start;
        lp_nxt        = '0;
        mac_en        = 1'b1;
        mac_op        = MOP_LCG;
        state_nxt     = S_LP;
      end
      S_LP: begin
        seed_nxt  = prod_r[31:0] + LCG_ADD;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        lp_nxt    = lp_new;
        mac_en    = 1'b1;
        mac_op    = MOP_SCALE;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr_r;
        ram_wdata = store_calc;
        if (fill_cnt_r == AW'(1)) begin
          prev_nxt   = '0;
          active_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          fill_cnt_nxt  = fill_cnt_r - AW'(1);
          fill_addr_nxt = wrap_inc(fill_addr_r);
          mac_en        = 1'b1;
          mac_op        = MOP_LCG;
          state_nxt     = S_LP;
        end
      end
      S_RD1: begin
        ram_raddr = i1_r;
        a_nxt     = ram_rdata;
        state_nxt = S_INTERP;
      end
      S_INTERP: begin
        mac_en    = 1'b1;
        mac_op    = MOP_INTERP;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        y_nxt     = y_calc;
        state_nxt = S_FBK;
      end
      S_FBK: begin
        mac_en    = 1'b1;
        mac_op    = MOP_DECAY;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = active_r ? y_r : '0;
          out_act_nxt    = active_r;
          if (active_r) begin
            ram_we    = 1'b1;
            ram_waddr = wp_r;
            ram_wdata = fb_calc;
            prev_nxt  = y_r;
            wp_nxt    = wrap_inc(wp_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sample_rate_r <= SR_RESET;
      decay_gain_r  <= GAIN_RESET;
      wp_r          <= '0;
      loop_len_r    <= '0;
      prev_r        <= '0;
      active_r      <= 1'b0;
      seed_r        <= SEED_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      loop_len_r  <= loop_len_nxt;
      prev_r      <= prev_nxt;
      active_r    <= active_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SAMPLE_RATE: sample_rate_r <= cfg_wdata[SR_W-1:0];
          CFG_DECAY_GAIN:  decay_gain_r  <= cfg_wdata[GAIN_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lp_r         <= lp_nxt;
    amp_r        <= amp_nxt;
    fill_cnt_r   <= fill_cnt_nxt;
    fill_addr_r  <= fill_addr_nxt;
    i1_r         <= i1_nxt;
    frac_r       <= frac_nxt;
    a_r          <= a_nxt;
    y_r          <= y_nxt;
    out_sample_r <= out_sample_nxt;
    out_act_r    <= out_act_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_voice_active = out_act_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the division wait");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider running while sequencer is not waiting on it");

  a_fill_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE) |-> (fill_cnt_r != '0))
    else $error("noise fill store with empty count");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (loop_len_r >= LEN_LO && loop_len_r <= LEN_HI))
    else $error("loop length outside clamp range on an active voice");

  a_idle_voice_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_act_r) |-> (out_sample_r == '0))
    else $error("inactive voice produced a nonzero sample");
`endif

endmodule

// File: tb/ksv_voice_checker.sv
// Scoreboard for the plucked-string voice: follows config writes and input transfers,
// predicts every tick result and compares it field by field with the result channel.
// Depends on ksv_pkg.
module ksv_voice_checker import ksv_pkg::*; #(
  parameter bit PLUCK_ACTION = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_action,
  input  logic [FREQ_W-1:0]       in_freq_hz,
  input  logic [AMP_W-1:0]        in_amplitude,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [SMP_W-1:0] out_sample,
  input  logic                    out_voice_active,
  output int                      fail_count,
  output int                      pending
);

  localparam int DEPTH = LINE_DEPTH_DEF;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    voice_active;
  } voice_out_t;

  voice_out_t expected_q[$];

  // shadow copy of the string state
  logic signed [SMP_W-1:0] tap_mem [DEPTH];
  int unsigned             wr_ptr;
  longint                  loop_len_q16;
  longint                  last_out;
  bit                      voice_on;
  logic [31:0]             lcg_state;
  logic [SR_W-1:0]         rate_reg;
  logic [GAIN_W-1:0]       gain_reg;

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic pluck_string(logic [FREQ_W-1:0] freq, logic [AMP_W-1:0] amp_in);
    longint      lo, hi, q, amp, lp, x;
    int unsigned n, idx;
    lo = longint'(MIN_LEN) << 16;
    hi = longint'(DEPTH - MIN_LEN) << 16;
    if (freq == 0) begin
      loop_len_q16 = hi;
    end else begin
      q = (longint'(rate_reg) << 24) / longint'(freq);
      if (q < lo + HALF_Q16) begin
        loop_len_q16 = lo;
      end else if (q - HALF_Q16 > hi) begin
        loop_len_q16 = hi;
      end else begin
        loop_len_q16 = q - HALF_Q16;
      end
    end
    amp = (amp_in > AMP_FULL) ? longint'(AMP_FULL) : longint'(amp_in);
    n = int'(loop_len_q16 >> 16) + 2;
    lp = 0;
    // smoothed noise lands in the n samples just behind the write pointer
    for (int i = 0; i < n; i++) begin
      lcg_state = lcg_state * LCG_MUL + LCG_ADD;
      x = longint'($signed(lcg_state[31:16]));
      lp = (lp + x) >>> 1;
      idx = (wr_ptr + DEPTH - n + i) % DEPTH;
      tap_mem[idx] = SMP_W'(clip16((lp * amp) >>> 15));
    end
    last_out = 0;
    voice_on = 1'b1;
  endtask

  function automatic voice_out_t tick_string();
    voice_out_t  r;
    longint      pos, a, b, f, y, fb;
    int unsigned i0;
    r = '0;
    if (!voice_on) return r;
    pos = (longint'(wr_ptr) << 16) + (longint'(DEPTH) << 16) - loop_len_q16;
    i0 = int'((pos >> 16) % DEPTH);
    f = pos & 64'hFFFF;
    a = tap_mem[i0];
    b = tap_mem[(i0 + 1) % DEPTH];
    y = clip16(a + (((b - a) * f) >>> 16));
    fb = ((y + last_out) * longint'(gain_reg)) >>> 17;
    last_out = y;
    tap_mem[wr_ptr] = SMP_W'(clip16(fb));
    wr_ptr = (wr_ptr + 1) % DEPTH;
    r.sample = SMP_W'(y);
    r.voice_active = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    fail_count++;
    if (fail_count <= 100) begin
      $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    voice_out_t want;
    if (!rst_n) begin
      foreach (tap_mem[i]) tap_mem[i] = '0;
      wr_ptr = 0;
      loop_len_q16 = 0;
      last_out = 0;
      voice_on = 1'b0;
      lcg_state = SEED_RESET;
      rate_reg = SR_RESET;
      gain_reg = GAIN_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == CFG_SAMPLE_RATE) begin
          rate_reg = cfg_wdata[SR_W-1:0];
        end else if (cfg_reg_t'(cfg_index) == CFG_DECAY_GAIN) begin
          gain_reg = cfg_wdata[GAIN_W-1:0];
        end
      end
      // retire before predicting: a result never belongs to a same-edge input
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, sample", longint'(out_sample), 0);
        end else begin
          want = expected_q.pop_front();
          if (out_sample !== want.sample) begin
            report_mismatch("sample", longint'(out_sample), longint'(want.sample));
          end
          if (out_voice_active !== want.voice_active) begin
            report_mismatch("voice_active", longint'(out_voice_active),
                            longint'(want.voice_active));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_action == PLUCK_ACTION) begin
          pluck_string(in_freq_hz, in_amplitude);
        end else begin
          expected_q.push_back(tick_string());
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/tb_plucked_string_synth_voice.sv
// Testbench top for the plucked-string voice: clock, reset, config writes, pluck and
// tick stimulus with random idling on both channels, watchdog and verdict.
// Depends on ksv_pkg, plucked_string_synth_voice and ksv_voice_checker.
module tb_plucked_string_synth_voice;
  import ksv_pkg::*;

  localparam bit ACT_TICK    = 1'b0;
  localparam bit ACT_PLUCK   = 1'b1;
  localparam int STUCK_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 3200;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DAT_W-1:0]    cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_action;
  logic [FREQ_W-1:0]       in_freq_hz;
  logic [AMP_W-1:0]        in_amplitude;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SMP_W-1:0] out_sample;
  logic                    out_voice_active;

  int fail_count;
  int pending;
  int results_seen;
  int stuck_cycles;
  bit calm;

  plucked_string_synth_voice u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_freq_hz       (in_freq_hz),
    .in_amplitude     (in_amplitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_voice_active (out_voice_active)
  );

  ksv_voice_checker #(.PLUCK_ACTION(ACT_PLUCK)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_freq_hz       (in_freq_hz),
    .in_amplitude     (in_amplitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_voice_active (out_voice_active),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one transfer on the input channel; entered and left at a falling edge
  task automatic send_item(bit act, logic [FREQ_W-1:0] freq, logic [AMP_W-1:0] amp);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_freq_hz   <= freq;
    in_amplitude <= amp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid, wait for every expected result, then an optional settle time
  task automatic hold_until_drained(int extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_regs(logic [SR_W-1:0] rate, logic [GAIN_W-1:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_RATE;
    cfg_wdata <= CFG_DAT_W'(rate);
    @(negedge clk);
    cfg_index <= CFG_DECAY_GAIN;
    cfg_wdata <= CFG_DAT_W'(gain);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned       rates [4];
    int unsigned       gains [4];
    int unsigned       sel;
    logic [FREQ_W-1:0] freq;
    logic [AMP_W-1:0]  amp;

    cfg_we       = 1'b0;
    cfg_index    = CFG_SAMPLE_RATE;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_action    = ACT_TICK;
    in_freq_hz   = '0;
    in_amplitude = '0;
    calm         = 1'b0;
    rst_n        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset config
    send_item(ACT_TICK, '1, '1);                      // voice not plucked yet
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_PLUCK, '0, AMP_FULL);               // zero freq: longest loop
    repeat (3) send_item(ACT_TICK, FREQ_W'($urandom), AMP_W'($urandom));
    send_item(ACT_PLUCK, FREQ_W'(1), 16'hFFFF);       // amp above full scale
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_PLUCK, '1, '0);                     // shortest loop, silent
    repeat (2) send_item(ACT_TICK, '1, '1);
    send_item(ACT_PLUCK, FREQ_W'(24576000), 16'h7FFF);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_PLUCK, FREQ_W'(2730666), 16'h0001); // around the minimum clamp
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_PLUCK, FREQ_W'(2730667), 16'h8001);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_PLUCK, FREQ_W'(614400), 16'h4000);
    repeat (3) send_item(ACT_TICK, FREQ_W'($urandom), AMP_W'($urandom));

    rates = '{8000, 96000, 0, 44100};
    gains = '{0, 65535, 0, 65274};
    rates[2] = $urandom_range(8000, 96000);
    gains[2] = $urandom_range(0, 65535);

    for (int p = 0; p < 4; p++) begin
      hold_until_drained(DRAIN_WAIT);
      write_regs(SR_W'(rates[p]), GAIN_W'(gains[p]));
      for (int k = 0; k < 150; k++) begin
        if (p == 3 && k == 50) calm = 1'b1;
        if (p == 1 && k == 75) hold_until_drained(0);
        if (k == 0 || $urandom_range(7) == 0) begin
          sel = $urandom_range(99);
          if (sel < 70) begin
            freq = FREQ_W'((rates[p] * 256) / $urandom_range(4, 48) + $urandom_range(0, 255));
          end else if (sel < 92) begin
            freq = FREQ_W'($urandom);
          end else begin
            freq = FREQ_W'($urandom_range(1, 4000));  // low frequency: mostly long loops, slow fill
          end
          sel = $urandom_range(9);
          if (sel < 6) begin
            amp = AMP_W'($urandom_range(0, 32768));
          end else if (sel < 8) begin
            amp = AMP_W'($urandom);
          end else if (sel == 8) begin
            amp = AMP_FULL;
          end else begin
            amp = 16'hFFFF;
          end
          send_item(ACT_PLUCK, freq, amp);
        end else begin
          send_item(ACT_TICK, FREQ_W'($urandom), AMP_W'($urandom));
        end
      end
    end

    hold_until_drained(DRAIN_WAIT);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random stall bursts plus one long hold-off to back the voice up
  initial begin
    bit held_long;
    held_long = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held_long && results_seen >= 150) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (out_valid && !out_stall) results_seen <= results_seen + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
